FILE: rtl/psc_pkg.sv
// Shared widths, register indexes and arithmetic constants for the pressure compensation block.
`default_nettype none

package psc_pkg;

   localparam int RAW_W      = 24;
   localparam int COEFF_W    = 16;
   localparam int TEMP_W     = 19;
   localparam int PRES_W     = 23;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_MODEL_SELECT,
      REG_SENS,
      REG_OFFSET,
      REG_SENS_TEMP,
      REG_OFFSET_TEMP,
      REG_REF_TEMP,
      REG_TEMP_SLOPE
   } reg_index_type;

   localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
   localparam logic signed [TEMP_W:0]   VLOW_BIAS = 20'sd3500;

   // floor(2^32 / divisor), one correction step recovers the exact quotient
   localparam logic [28:0] RECIP_10  = 29'd429496729;
   localparam logic [28:0] RECIP_100 = 29'd42949672;
   localparam logic [6:0]  DIV_10    = 7'd10;
   localparam logic [6:0]  DIV_100   = 7'd100;

   localparam logic [27:0] PRES_POS_LIMIT = 28'd4194303;
   localparam logic [27:0] PRES_NEG_LIMIT = 28'd4194304;
   localparam logic signed [PRES_W-1:0] PRES_MAX = 23'h3FFFFF;
   localparam logic signed [PRES_W-1:0] PRES_MIN = 23'h400000;

endpackage

`default_nettype wire

FILE: rtl/psc_if.sv
// Request and response channel interfaces for the pressure compensation block.
`default_nettype none

interface psc_req_if import psc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RAW_W-1:0]  raw_pressure;
   logic [RAW_W-1:0]  raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface psc_rsp_if import psc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi;
   logic signed [PRES_W-1:0] pressure_mbar;

   modport source (output valid, output temperature_centi, output pressure_mbar, input ready);
   modport sink   (input valid, input temperature_centi, input pressure_mbar, output ready);
endinterface

`default_nettype wire

FILE: rtl/pressure_sensor_compensation.sv
// Second-order pressure and temperature compensation pipeline with APB calibration registers.
//
// A request carries a raw pressure and a raw temperature conversion on req_ch
// (valid/ready). The response on rsp_ch carries temperature in 0.01 degC and
// pressure in whole mbar, saturated to the 23-bit range.
// Calibration words and the model select sit behind the APB port, one register
// per word at byte address 4*index; write them only while the pipeline is empty.
// There are thirteen register stages, the first taking the request and the last
// being the output register. A new request enters every cycle while rsp_ch.ready
// is high, so sustained throughput is then one result per cycle; the wide pressure
// product is split into two partial products over two stages and the divide by
// ten or a hundred is a reciprocal multiply with one correction step.
// Reset clears every stage valid bit and all calibration registers to zero.
// When rsp_ch.ready is low the output holds; earlier stages keep filling empty
// slots, and req_ch.ready drops only once every stage holds a request.
`default_nettype none

module pressure_sensor_compensation import psc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   psc_req_if.sink               req_ch,
   psc_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NSTAGE = 13;

   function automatic logic signed [41:0] shr_trunc42(input logic signed [41:0] x,
                                                      input int unsigned sh);
      logic signed [41:0] bias;
      bias = x[41] ? ((42'sd1 <<< sh) - 42'sd1) : 42'sd0;
      return (x + bias) >>> sh;
   endfunction

   // ---------------------------------------------------------------- registers
   logic               model_sel_ff;
   logic [COEFF_W-1:0] sens_coeff_ff, offset_coeff_ff, sens_temp_coeff_ff;
   logic [COEFF_W-1:0] offset_temp_coeff_ff, ref_temp_coeff_ff, temp_slope_coeff_ff;
   reg_index_type      csr_index;
   logic               csr_write;
   logic               two_bar;

   assign csr_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign two_bar   = model_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_sel_ff         <= 1'b0;
         sens_coeff_ff        <= '0;
         offset_coeff_ff      <= '0;
         sens_temp_coeff_ff   <= '0;
         offset_temp_coeff_ff <= '0;
         ref_temp_coeff_ff    <= '0;
         temp_slope_coeff_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MODEL_SELECT: model_sel_ff         <= pwdata[0];
            REG_SENS:         sens_coeff_ff        <= pwdata[COEFF_W-1:0];
            REG_OFFSET:       offset_coeff_ff      <= pwdata[COEFF_W-1:0];
            REG_SENS_TEMP:    sens_temp_coeff_ff   <= pwdata[COEFF_W-1:0];
            REG_OFFSET_TEMP:  offset_temp_coeff_ff <= pwdata[COEFF_W-1:0];
            REG_REF_TEMP:     ref_temp_coeff_ff    <= pwdata[COEFF_W-1:0];
            REG_TEMP_SLOPE:   temp_slope_coeff_ff  <= pwdata[COEFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MODEL_SELECT: prdata = {31'b0, model_sel_ff};
         REG_SENS:         prdata = {16'b0, sens_coeff_ff};
         REG_OFFSET:       prdata = {16'b0, offset_coeff_ff};
         REG_SENS_TEMP:    prdata = {16'b0, sens_temp_coeff_ff};
         REG_OFFSET_TEMP:  prdata = {16'b0, offset_temp_coeff_ff};
         REG_REF_TEMP:     prdata = {16'b0, ref_temp_coeff_ff};
         REG_TEMP_SLOPE:   prdata = {16'b0, temp_slope_coeff_ff};
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ stage control
   logic [NSTAGE-1:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_ch.ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign valid_in     = {valid_ff[NSTAGE-2:0], req_ch.valid};
   assign req_ch.ready = stage_en[0];
   assign rsp_ch.valid = valid_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (stage_en[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   // ------------------------------------------------------------- datapath
   // s0: dT
   logic [RAW_W-1:0]  s0_d1_ff;
   logic signed [24:0] s0_dt_ff, s0_dt_in;
   assign s0_dt_in = $signed({1'b0, req_ch.raw_temperature})
                   - $signed({1'b0, ref_temp_coeff_ff, 8'b0});

   // s1: products on dT
   logic [RAW_W-1:0]   s1_d1_ff;
   logic signed [41:0] s1_dtc6_ff, s1_c3dt_ff, s1_c4dt_ff;
   logic signed [41:0] s1_dtc6_in, s1_c3dt_in, s1_c4dt_in;
   logic signed [49:0] s1_dtsq_full;
   logic [48:0]        s1_dtsq_ff;
   assign s1_dtc6_in   = s0_dt_ff * $signed({1'b0, temp_slope_coeff_ff});
   assign s1_c3dt_in   = s0_dt_ff * $signed({1'b0, sens_temp_coeff_ff});
   assign s1_c4dt_in   = s0_dt_ff * $signed({1'b0, offset_temp_coeff_ff});
   assign s1_dtsq_full = s0_dt_ff * s0_dt_ff;

   // s2: first-order terms, temperature correction candidates
   logic [RAW_W-1:0]         s2_d1_ff;
   logic signed [TEMP_W-1:0] s2_dtemp_ff, s2_dtemp_in;
   logic signed [40:0]       s2_sens_ff, s2_off_ff, s2_sens_in, s2_off_in;
   logic [17:0]              s2_ti_lo30_ff, s2_ti_lo2_ff;
   logic [12:0]              s2_ti_hi30_ff;
   logic signed [41:0]       c3_term, c4_term;
   logic signed [40:0]       sens_base, off_base;
   logic [50:0]              dtsq_x3;
   logic [52:0]              dtsq_x11;

   always_comb begin
      s2_dtemp_in = TEMP_W'(shr_trunc42(s1_dtc6_ff, 23));
      if (two_bar) begin
         c3_term   = shr_trunc42(s1_c3dt_ff, 7);
         c4_term   = shr_trunc42(s1_c4dt_ff, 6);
         sens_base = $signed({9'b0, sens_coeff_ff, 16'b0});
         off_base  = $signed({8'b0, offset_coeff_ff, 17'b0});
      end else begin
         c3_term   = shr_trunc42(s1_c3dt_ff, 8);
         c4_term   = shr_trunc42(s1_c4dt_ff, 7);
         sens_base = $signed({10'b0, sens_coeff_ff, 15'b0});
         off_base  = $signed({9'b0, offset_coeff_ff, 16'b0});
      end
      s2_sens_in = sens_base + 41'(c3_term);
      s2_off_in  = off_base + 41'(c4_term);
      dtsq_x3    = {2'b0, s1_dtsq_ff} + {1'b0, s1_dtsq_ff, 1'b0};
      dtsq_x11   = {1'b0, s1_dtsq_ff, 3'b0} + {3'b0, s1_dtsq_ff, 1'b0} + {4'b0, s1_dtsq_ff};
   end

   // s3: squares, branch flags, temperature correction select
   logic [RAW_W-1:0]         s3_d1_ff;
   logic signed [TEMP_W-1:0] s3_temp_ff, s3_temp_in;
   logic signed [40:0]       s3_sens_ff, s3_off_ff;
   logic [17:0]              s3_ti_ff, s3_ti_in;
   logic [34:0]              s3_sqt_ff, s3_sqv_ff;
   logic                     s3_low_ff, s3_vlow_ff;
   logic signed [TEMP_W:0]   vt;
   logic signed [37:0]       sqt_full;
   logic signed [39:0]       sqv_full;

   always_comb begin
      s3_temp_in = TEMP_REF + s2_dtemp_ff;
      vt         = {s2_dtemp_ff[TEMP_W-1], s2_dtemp_ff} + VLOW_BIAS;
      sqt_full   = s2_dtemp_ff * s2_dtemp_ff;
      sqv_full   = vt * vt;
      if (s2_dtemp_ff[TEMP_W-1]) begin
         s3_ti_in = two_bar ? s2_ti_lo2_ff : s2_ti_lo30_ff;
      end else begin
         s3_ti_in = two_bar ? 18'd0 : {5'b0, s2_ti_hi30_ff};
      end
   end

   // s4: second-order offset and sensitivity
   logic [RAW_W-1:0]         s4_d1_ff;
   logic signed [TEMP_W-1:0] s4_temp_ff, s4_temp_in;
   logic signed [40:0]       s4_sens_ff, s4_off_ff, s4_sens_in, s4_off_in;
   logic [40:0]              sq41, sv41, offi, sensi;

   always_comb begin
      sq41 = {6'b0, s3_sqt_ff};
      sv41 = {6'b0, s3_sqv_ff};
      offi  = '0;
      sensi = '0;
      if (two_bar) begin
         if (s3_low_ff) begin
            offi  = ((sq41 << 5) - sq41) >> 3;
            sensi = ((sq41 << 6) - sq41) >> 5;
         end
      end else if (s3_low_ff) begin
         offi  = ((sq41 << 1) + sq41) >> 1;
         sensi = ((sq41 << 2) + sq41) >> 3;
         if (s3_vlow_ff) begin
            offi  = offi + ((sv41 << 3) - sv41);
            sensi = sensi + (sv41 << 2);
         end
      end else begin
         offi = sq41 >> 4;
      end
      s4_sens_in = s3_sens_ff - $signed(sensi);
      s4_off_in  = s3_off_ff - $signed(offi);
      s4_temp_in = s3_temp_ff - $signed({1'b0, s3_ti_ff});
   end

   // s5: D1 * SENS as two partial products
   logic [43:0]              s5_pplo_ff, s5_pplo_in;
   logic signed [45:0]       s5_pphi_ff, s5_pphi_in;
   logic signed [40:0]       s5_off_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff;
   assign s5_pplo_in = s4_d1_ff * s4_sens_ff[19:0];
   assign s5_pphi_in = $signed({1'b0, s4_d1_ff}) * $signed(s4_sens_ff[40:20]);

   // s6: recombine
   logic signed [65:0]       s6_prod_ff, s6_prod_in;
   logic signed [40:0]       s6_off_ff;
   logic signed [TEMP_W-1:0] s6_temp_ff;
   assign s6_prod_in = $signed({s5_pphi_ff, 20'b0}) + $signed({22'b0, s5_pplo_ff});

   // s7: divide by 2^21
   logic signed [44:0]       s7_a_ff, s7_a_in;
   logic signed [40:0]       s7_off_ff;
   logic signed [TEMP_W-1:0] s7_temp_ff;
   logic signed [65:0]       prod_bias;
   assign prod_bias = s6_prod_ff[65] ? 66'sd2097151 : 66'sd0;
   assign s7_a_in   = 45'((s6_prod_ff + prod_bias) >>> 21);

   // s8: subtract offset
   logic signed [45:0]       s8_x_ff, s8_x_in;
   logic signed [TEMP_W-1:0] s8_temp_ff;
   assign s8_x_in = $signed({s7_a_ff[44], s7_a_ff})
                  - $signed({{5{s7_off_ff[40]}}, s7_off_ff});

   // s9: magnitude, divide by Q
   logic [29:0]              s9_m_ff, s9_m_in;
   logic                     s9_neg_ff;
   logic signed [TEMP_W-1:0] s9_temp_ff;
   logic [45:0]              x_mag, x_shr;
   always_comb begin
      x_mag   = s8_x_ff[45] ? $unsigned(-s8_x_ff) : $unsigned(s8_x_ff);
      x_shr   = two_bar ? (x_mag >> 15) : (x_mag >> 13);
      s9_m_in = x_shr[29:0];
   end

   // s10: reciprocal multiply
   logic [58:0]              s10_mk_ff, s10_mk_in;
   logic [29:0]              s10_m_ff;
   logic                     s10_neg_ff;
   logic signed [TEMP_W-1:0] s10_temp_ff;
   logic [28:0]              recip;
   logic [6:0]               rdiv;
   assign recip     = two_bar ? RECIP_100 : RECIP_10;
   assign rdiv      = two_bar ? DIV_100 : DIV_10;
   assign s10_mk_in = s9_m_ff * recip;

   // s11: quotient estimate and remainder
   logic [26:0]              s11_qe_ff, s11_qe_in;
   logic [7:0]               s11_r_ff, s11_r_in;
   logic                     s11_neg_ff;
   logic signed [TEMP_W-1:0] s11_temp_ff;
   logic [33:0]              qe_times_r;
   logic [29:0]              rem_full;
   always_comb begin
      s11_qe_in  = s10_mk_ff[58:32];
      qe_times_r = s11_qe_in * rdiv;
      rem_full   = s10_m_ff - qe_times_r[29:0];
      s11_r_in   = rem_full[7:0];
   end

   // s12: correction, sign, saturation
   logic signed [TEMP_W-1:0] s12_temp_ff;
   logic signed [PRES_W-1:0] s12_pres_ff, s12_pres_in;
   logic [27:0]              q_mag, q_neg;
   always_comb begin
      q_mag = {1'b0, s11_qe_ff} + 28'(s11_r_ff >= {1'b0, rdiv});
      q_neg = 28'(-q_mag);
      if (s11_neg_ff) begin
         s12_pres_in = (q_mag > PRES_NEG_LIMIT) ? PRES_MIN : $signed(q_neg[PRES_W-1:0]);
      end else begin
         s12_pres_in = (q_mag > PRES_POS_LIMIT) ? PRES_MAX : $signed(q_mag[PRES_W-1:0]);
      end
   end

   assign rsp_ch.temperature_centi = s12_temp_ff;
   assign rsp_ch.pressure_mbar     = s12_pres_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_d1_ff <= req_ch.raw_pressure;
         s0_dt_ff <= s0_dt_in;
      end
      if (stage_en[1]) begin
         s1_d1_ff   <= s0_d1_ff;
         s1_dtc6_ff <= s1_dtc6_in;
         s1_c3dt_ff <= s1_c3dt_in;
         s1_c4dt_ff <= s1_c4dt_in;
         s1_dtsq_ff <= s1_dtsq_full[48:0];
      end
      if (stage_en[2]) begin
         s2_d1_ff      <= s1_d1_ff;
         s2_dtemp_ff   <= s2_dtemp_in;
         s2_sens_ff    <= s2_sens_in;
         s2_off_ff     <= s2_off_in;
         s2_ti_lo30_ff <= dtsq_x3[50:33];
         s2_ti_lo2_ff  <= dtsq_x11[52:35];
         s2_ti_hi30_ff <= s1_dtsq_ff[48:36];
      end
      if (stage_en[3]) begin
         s3_d1_ff   <= s2_d1_ff;
         s3_temp_ff <= s3_temp_in;
         s3_sens_ff <= s2_sens_ff;
         s3_off_ff  <= s2_off_ff;
         s3_ti_ff   <= s3_ti_in;
         s3_sqt_ff  <= sqt_full[34:0];
         s3_sqv_ff  <= sqv_full[34:0];
         s3_low_ff  <= s2_dtemp_ff[TEMP_W-1];
         s3_vlow_ff <= vt[TEMP_W];
      end
      if (stage_en[4]) begin
         s4_d1_ff   <= s3_d1_ff;
         s4_temp_ff <= s4_temp_in;
         s4_sens_ff <= s4_sens_in;
         s4_off_ff  <= s4_off_in;
      end
      if (stage_en[5]) begin
         s5_pplo_ff <= s5_pplo_in;
         s5_pphi_ff <= s5_pphi_in;
         s5_off_ff  <= s4_off_ff;
         s5_temp_ff <= s4_temp_ff;
      end
      if (stage_en[6]) begin
         s6_prod_ff <= s6_prod_in;
         s6_off_ff  <= s5_off_ff;
         s6_temp_ff <= s5_temp_ff;
      end
      if (stage_en[7]) begin
         s7_a_ff    <= s7_a_in;
         s7_off_ff  <= s6_off_ff;
         s7_temp_ff <= s6_temp_ff;
      end
      if (stage_en[8]) begin
         s8_x_ff    <= s8_x_in;
         s8_temp_ff <= s7_temp_ff;
      end
      if (stage_en[9]) begin
         s9_m_ff    <= s9_m_in;
         s9_neg_ff  <= s8_x_ff[45];
         s9_temp_ff <= s8_temp_ff;
      end
      if (stage_en[10]) begin
         s10_mk_ff   <= s10_mk_in;
         s10_m_ff    <= s9_m_ff;
         s10_neg_ff  <= s9_neg_ff;
         s10_temp_ff <= s9_temp_ff;
      end
      if (stage_en[11]) begin
         s11_qe_ff   <= s11_qe_in;
         s11_r_ff    <= s11_r_in;
         s11_neg_ff  <= s10_neg_ff;
         s11_temp_ff <= s10_temp_ff;
      end
      if (stage_en[12]) begin
         s12_temp_ff <= s11_temp_ff;
         s12_pres_ff <= s12_pres_in;
      end
   end

endmodule

`default_nettype wire
